### rtl/stab_pkg.sv
package stab_pkg;

    localparam int MAX_QUBITS = 64;
    localparam int NROWS      = 2 * MAX_QUBITS;
    localparam int QW         = $clog2(MAX_QUBITS);
    localparam int RW         = $clog2(NROWS);
    localparam int CW         = RW + 1;

    localparam logic [3:0] ACT_RESET = 4'd0;
    localparam logic [3:0] ACT_H     = 4'd1;
    localparam logic [3:0] ACT_S     = 4'd2;
    localparam logic [3:0] ACT_SDG   = 4'd3;
    localparam logic [3:0] ACT_X     = 4'd4;
    localparam logic [3:0] ACT_Y     = 4'd5;
    localparam logic [3:0] ACT_Z     = 4'd6;
    localparam logic [3:0] ACT_CNOT  = 4'd7;
    localparam logic [3:0] ACT_SWAP  = 4'd8;
    localparam logic [3:0] ACT_MEAS  = 4'd9;

    typedef struct packed {
        logic                  sign;
        logic [MAX_QUBITS-1:0] z;
        logic [MAX_QUBITS-1:0] x;
    } t_row;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_GATE,
        S_SCAN,
        S_SUM,
        S_FIXD,
        S_FIXP,
        S_DET,
        S_OUT
    } t_state;

    // sum mod 4 of the pauli product phase, source (sx,sz) onto target (tx,tz)
    function automatic logic [1:0] phase_word(
        input logic [MAX_QUBITS-1:0] sx,
        input logic [MAX_QUBITS-1:0] sz,
        input logic [MAX_QUBITS-1:0] tx,
        input logic [MAX_QUBITS-1:0] tz
    );
        logic [MAX_QUBITS-1:0] plus;
        logic [MAX_QUBITS-1:0] minus;
        logic [1:0]            cp;
        logic [1:0]            cm;
        plus  = (sx & sz & ~tx & tz) | (sx & ~sz & tx & tz) | (~sx & sz & tx & ~tz);
        minus = (sx & sz & tx & ~tz) | (sx & ~sz & ~tx & tz) | (~sx & sz & tx & tz);
        cp = 2'($countones(plus));
        cm = 2'($countones(minus));
        return cp - cm;
    endfunction

endpackage

### rtl/stabilizer_tableau_engine.sv
// channel   | dir | handshake                   | payload
// s_axis    | in  | tvalid / tready             | tdata: action, qubit_a, qubit_b, random_bit
// m_axis    | out | tvalid / tready             | tdata: outcome
// cfg       | in  | wen, no wait                | wdata: active_qubits
// tableau rows sit in one ram, one row read and one row written per cycle
// gates sweep all 2n rows; measure scans the stabilizer rows, then sweeps all 2n
// rows for a random outcome or walks the destabilizer rows for a deterministic one
// reset and every cfg write or reset action rewrite all 128 rows of the ram
// the result register frees the engine; it waits only if a second result is due
module stabilizer_tableau_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // action[3:0], qubit_a[9:4], qubit_b[15:10], random_bit[16]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,  // outcome[0]
    input  logic        i_cfg_wen,
    input  logic [6:0]  i_cfg_wdata
);

    localparam int QW = stab_pkg::QW;
    localparam int RW = stab_pkg::RW;
    localparam int CW = stab_pkg::CW;

    stab_pkg::t_state r_state, n_state;
    logic [RW-1:0]    r_n, n_n;
    logic [3:0]       r_act, n_act;
    logic [QW-1:0]    r_a, n_a;
    logic [QW-1:0]    r_b, n_b;
    logic             r_rnd, n_rnd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_vld, n_vld;
    logic [RW-1:0]    r_qa, n_qa;
    stab_pkg::t_row   r_p, n_p;
    logic [RW-1:0]    r_pidx, n_pidx;
    logic [stab_pkg::MAX_QUBITS-1:0] r_sx, n_sx;
    logic [stab_pkg::MAX_QUBITS-1:0] r_sz, n_sz;
    logic [1:0]       r_ph, n_ph;
    logic             r_dsub, n_dsub;
    logic             r_pend, n_pend;
    logic             r_res, n_res;
    logic             r_ovld, n_ovld;

    logic             s_in_acc;
    logic             s_res_load;
    logic             s_issue;
    logic [RW-1:0]    s_raddr;
    logic             s_we;
    logic [RW-1:0]    s_waddr;
    stab_pkg::t_row   s_wdata;
    stab_pkg::t_row   s_rdata;
    stab_pkg::t_row   s_gate_row;
    stab_pkg::t_row   s_sum_row;
    stab_pkg::t_row   s_init_row;
    logic [CW-1:0]    s_n2;
    logic             s_last;
    logic [3:0]       s_act_in;
    logic [QW-1:0]    s_a_in;
    logic [QW-1:0]    s_b_in;
    logic             s_a_ok;
    logic             s_b_ok;
    logic [RW-1:0]    s_init_off;
    logic [RW-1:0]    s_cfg_n;

    assign s_act_in = i_s_axis_tdata[3:0];
    assign s_a_in   = i_s_axis_tdata[9:4];
    assign s_b_in   = i_s_axis_tdata[15:10];
    assign s_a_ok   = {1'b0, s_a_in} < r_n;
    assign s_b_ok   = {1'b0, s_b_in} < r_n;
    assign s_n2     = {r_n, 1'b0};
    assign s_last   = {1'b0, r_qa} == (s_n2 - CW'(1));
    assign s_in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign s_res_load = (r_state == stab_pkg::S_OUT) && (!r_ovld || i_m_axis_tready);

    always_comb begin
        if (i_cfg_wdata == 7'd0) begin
            s_cfg_n = RW'(1);
        end else if (i_cfg_wdata > 7'(stab_pkg::MAX_QUBITS)) begin
            s_cfg_n = RW'(stab_pkg::MAX_QUBITS);
        end else begin
            s_cfg_n = RW'(i_cfg_wdata);
        end
    end

    // identity rows for the rewrite pass
    always_comb begin
        s_init_off = r_cnt[RW-1:0] - r_n;
        s_init_row = '0;
        if (r_cnt[RW-1:0] < r_n) begin
            s_init_row.x = stab_pkg::MAX_QUBITS'(1) << r_cnt[QW-1:0];
        end else if (r_cnt < s_n2) begin
            s_init_row.z = stab_pkg::MAX_QUBITS'(1) << s_init_off[QW-1:0];
        end
    end

    stab_tab_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    stab_row_alu u_alu (
        .i_act  (r_act),
        .i_qa   (r_a),
        .i_qb   (r_b),
        .i_row  (s_rdata),
        .i_src  (r_p),
        .o_gate (s_gate_row),
        .o_sum  (s_sum_row)
    );

    // outputs and ram port control
    always_comb begin
        o_s_axis_tready = (r_state == stab_pkg::S_IDLE);
        s_issue = 1'b0;
        s_raddr = r_cnt[RW-1:0];
        s_we    = 1'b0;
        s_waddr = r_qa;
        s_wdata = s_gate_row;
        case (r_state)
            stab_pkg::S_INIT: begin
                s_we    = 1'b1;
                s_waddr = r_cnt[RW-1:0];
                s_wdata = s_init_row;
            end
            stab_pkg::S_GATE: begin
                s_issue = r_cnt < s_n2;
                s_we    = r_vld;
            end
            stab_pkg::S_SCAN: begin
                s_issue = r_cnt < s_n2;
            end
            stab_pkg::S_SUM: begin
                s_issue = r_cnt < s_n2;
                s_we    = r_vld && (r_qa != r_pidx) && s_rdata.x[r_a];
                s_wdata = s_sum_row;
            end
            stab_pkg::S_FIXD: begin
                s_we    = 1'b1;
                s_waddr = r_pidx - r_n;
                s_wdata = r_p;
            end
            stab_pkg::S_FIXP: begin
                s_we    = 1'b1;
                s_waddr = r_pidx;
                s_wdata = '0;
                s_wdata.z = stab_pkg::MAX_QUBITS'(1) << r_a;
                s_wdata.sign = r_rnd;
            end
            stab_pkg::S_DET: begin
                s_issue = !r_vld && (r_cnt[RW-1:0] != r_n);
                s_raddr = r_dsub ? (r_n + r_cnt[RW-1:0]) : r_cnt[RW-1:0];
            end
            default: begin
                s_issue = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_act   = r_act;
        n_a     = r_a;
        n_b     = r_b;
        n_rnd   = r_rnd;
        n_cnt   = r_cnt;
        n_vld   = s_issue;
        n_qa    = s_raddr;
        n_p     = r_p;
        n_pidx  = r_pidx;
        n_sx    = r_sx;
        n_sz    = r_sz;
        n_ph    = r_ph;
        n_dsub  = r_dsub;
        n_pend  = r_pend;
        n_res   = s_res_load ? r_pend : r_res;
        n_ovld  = s_res_load ? 1'b1 : (i_m_axis_tready ? 1'b0 : r_ovld);
        if (s_issue && (r_state != stab_pkg::S_DET)) begin
            n_cnt = r_cnt + CW'(1);
        end
        case (r_state)
            stab_pkg::S_INIT: begin
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(stab_pkg::NROWS - 1)) begin
                    n_state = stab_pkg::S_IDLE;
                end
            end
            stab_pkg::S_IDLE: begin
                if (s_in_acc) begin
                    n_act = s_act_in;
                    n_a   = s_a_in;
                    n_b   = s_b_in;
                    n_rnd = i_s_axis_tdata[16];
                    n_cnt = '0;
                    case (s_act_in)
                        stab_pkg::ACT_RESET: n_state = stab_pkg::S_INIT;
                        stab_pkg::ACT_H, stab_pkg::ACT_S, stab_pkg::ACT_SDG,
                        stab_pkg::ACT_X, stab_pkg::ACT_Y, stab_pkg::ACT_Z: begin
                            if (s_a_ok) begin
                                n_state = stab_pkg::S_GATE;
                            end
                        end
                        stab_pkg::ACT_CNOT, stab_pkg::ACT_SWAP: begin
                            if (s_a_ok && s_b_ok && (s_a_in != s_b_in)) begin
                                n_state = stab_pkg::S_GATE;
                            end
                        end
                        stab_pkg::ACT_MEAS: begin
                            if (s_a_ok) begin
                                n_state = stab_pkg::S_SCAN;
                                n_cnt   = {1'b0, r_n};
                            end else begin
                                n_state = stab_pkg::S_OUT;
                                n_pend  = 1'b0;
                            end
                        end
                        default: n_state = stab_pkg::S_IDLE;
                    endcase
                end
            end
            stab_pkg::S_GATE: begin
                if (r_vld && s_last) begin
                    n_state = stab_pkg::S_IDLE;
                    n_vld   = 1'b0;
                end
            end
            stab_pkg::S_SCAN: begin
                if (r_vld && s_rdata.x[r_a]) begin
                    n_p     = s_rdata;
                    n_pidx  = r_qa;
                    n_state = stab_pkg::S_SUM;
                    n_cnt   = '0;
                    n_vld   = 1'b0;
                end else if (r_vld && s_last) begin
                    n_state = stab_pkg::S_DET;
                    n_cnt   = '0;
                    n_vld   = 1'b0;
                    n_sx    = '0;
                    n_sz    = '0;
                    n_ph    = '0;
                    n_dsub  = 1'b0;
                end
            end
            stab_pkg::S_SUM: begin
                if (r_vld && s_last) begin
                    n_state = stab_pkg::S_FIXD;
                    n_vld   = 1'b0;
                end
            end
            stab_pkg::S_FIXD: n_state = stab_pkg::S_FIXP;
            stab_pkg::S_FIXP: begin
                n_state = stab_pkg::S_OUT;
                n_pend  = r_rnd;
            end
            stab_pkg::S_DET: begin
                if (r_vld) begin
                    if (!r_dsub) begin
                        if (s_rdata.x[r_a]) begin
                            n_dsub = 1'b1;
                        end else begin
                            n_cnt = r_cnt + CW'(1);
                        end
                    end else begin
                        n_ph = r_ph + {s_rdata.sign, 1'b0}
                             + stab_pkg::phase_word(s_rdata.x, s_rdata.z, r_sx, r_sz);
                        n_sx   = r_sx ^ s_rdata.x;
                        n_sz   = r_sz ^ s_rdata.z;
                        n_dsub = 1'b0;
                        n_cnt  = r_cnt + CW'(1);
                    end
                end else if (r_cnt[RW-1:0] == r_n) begin
                    n_state = stab_pkg::S_OUT;
                    n_pend  = (r_ph == 2'd2);
                end
            end
            stab_pkg::S_OUT: begin
                if (s_res_load) begin
                    n_state = stab_pkg::S_IDLE;
                end
            end
            default: n_state = stab_pkg::S_IDLE;
        endcase
        if (i_cfg_wen) begin
            n_n     = s_cfg_n;
            n_state = stab_pkg::S_INIT;
            n_cnt   = '0;
            n_vld   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stab_pkg::S_INIT;
            r_n     <= RW'(stab_pkg::MAX_QUBITS);
            r_cnt   <= '0;
            r_vld   <= 1'b0;
            r_dsub  <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_cnt   <= n_cnt;
            r_vld   <= n_vld;
            r_dsub  <= n_dsub;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act  <= n_act;
        r_a    <= n_a;
        r_b    <= n_b;
        r_rnd  <= n_rnd;
        r_qa   <= n_qa;
        r_p    <= n_p;
        r_pidx <= n_pidx;
        r_sx   <= n_sx;
        r_sz   <= n_sz;
        r_ph   <= n_ph;
        r_pend <= n_pend;
        r_res  <= n_res;
    end

    assign o_m_axis_tvalid = r_ovld;
    assign o_m_axis_tdata  = {7'b0, r_res};

endmodule

### rtl/stab_tab_mem.sv
module stab_tab_mem (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [stab_pkg::RW-1:0] i_waddr,
    input  stab_pkg::t_row         i_wdata,
    input  logic [stab_pkg::RW-1:0] i_raddr,
    output stab_pkg::t_row         o_rdata
);

    stab_pkg::t_row r_mem [stab_pkg::NROWS];
    stab_pkg::t_row r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/stab_row_alu.sv
module stab_row_alu (
    input  logic [3:0]              i_act,
    input  logic [stab_pkg::QW-1:0] i_qa,
    input  logic [stab_pkg::QW-1:0] i_qb,
    input  stab_pkg::t_row          i_row,
    input  stab_pkg::t_row          i_src,
    output stab_pkg::t_row          o_gate,
    output stab_pkg::t_row          o_sum
);

    function automatic stab_pkg::t_row s_gate(input stab_pkg::t_row r,
                                              input logic [stab_pkg::QW-1:0] q);
        stab_pkg::t_row o;
        o = r;
        o.sign = r.sign ^ (r.x[q] & r.z[q]);
        o.z[q] = r.z[q] ^ r.x[q];
        return o;
    endfunction

    function automatic stab_pkg::t_row cx_gate(input stab_pkg::t_row r,
                                               input logic [stab_pkg::QW-1:0] c,
                                               input logic [stab_pkg::QW-1:0] t);
        stab_pkg::t_row o;
        logic xc;
        logic zc;
        logic xt;
        logic zt;
        xc = r.x[c];
        zc = r.z[c];
        xt = r.x[t];
        zt = r.z[t];
        o = r;
        o.sign = r.sign ^ (xc & zt & ~(xt ^ zc));
        o.x[t] = xt ^ xc;
        o.z[c] = zc ^ zt;
        return o;
    endfunction

    logic       bx;
    logic       bz;
    logic [1:0] acc;

    assign bx = i_row.x[i_qa];
    assign bz = i_row.z[i_qa];

    always_comb begin
        o_gate = i_row;
        case (i_act)
            stab_pkg::ACT_H: begin
                o_gate.sign    = i_row.sign ^ (bx & bz);
                o_gate.x[i_qa] = bz;
                o_gate.z[i_qa] = bx;
            end
            stab_pkg::ACT_S:    o_gate = s_gate(i_row, i_qa);
            stab_pkg::ACT_SDG:  o_gate = s_gate(s_gate(s_gate(i_row, i_qa), i_qa), i_qa);
            stab_pkg::ACT_X:    o_gate.sign = i_row.sign ^ bz;
            stab_pkg::ACT_Y:    o_gate.sign = i_row.sign ^ bx ^ bz;
            stab_pkg::ACT_Z:    o_gate.sign = i_row.sign ^ bx;
            stab_pkg::ACT_CNOT: o_gate = cx_gate(i_row, i_qa, i_qb);
            stab_pkg::ACT_SWAP: o_gate = cx_gate(cx_gate(cx_gate(i_row, i_qa, i_qb),
                                                          i_qb, i_qa), i_qa, i_qb);
            default:            o_gate = i_row;
        endcase
    end

    always_comb begin
        acc = {i_src.sign, 1'b0} + {i_row.sign, 1'b0}
            + stab_pkg::phase_word(i_src.x, i_src.z, i_row.x, i_row.z);
        o_sum.x    = i_row.x ^ i_src.x;
        o_sum.z    = i_row.z ^ i_src.z;
        o_sum.sign = (acc == 2'd2);
    end

endmodule

### tb/stabilizer_tableau_engine_tb.sv
module stabilizer_tableau_engine_tb;

    class tableau_scoreboard;
        bit [63:0] xr[128];
        bit [63:0] zr[128];
        bit        sg[128];
        bit [63:0] scr_x;
        bit [63:0] scr_z;
        int        nq;
        bit        outcome_q[$];
        int        errors;

        function new();
            nq = 64;
            errors = 0;
            clear_tableau();
        endfunction

        function void report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endfunction

        function void clear_tableau();
            for (int i = 0; i < 128; i++) begin
                xr[i] = '0;
                zr[i] = '0;
                sg[i] = 0;
            end
            scr_x = '0;
            scr_z = '0;
            for (int i = 0; i < nq; i++) begin
                xr[i][i] = 1;
                zr[nq + i][i] = 1;
            end
        endfunction

        function void configure(bit [6:0] v);
            nq = (v < 1) ? 1 : (v > 64) ? 64 : v;
            clear_tableau();
        endfunction

        function bit [1:0] phase_of(bit [63:0] sx, bit [63:0] sz, bit [63:0] tx,
                                    bit [63:0] tz);
            bit [63:0] p;
            bit [63:0] m;
            p = (sx & sz & ~tx & tz) | (sx & ~sz & tx & tz) | (~sx & sz & tx & ~tz);
            m = (sx & sz & tx & ~tz) | (sx & ~sz & ~tx & tz) | (~sx & sz & tx & tz);
            return 2'($countones(p) + 3 * $countones(m));
        endfunction

        function void add_row(int s, int t);
            bit [1:0] acc;
            acc = 2 * sg[s] + 2 * sg[t] + phase_of(xr[s], zr[s], xr[t], zr[t]);
            xr[t] ^= xr[s];
            zr[t] ^= zr[s];
            sg[t] = (acc == 2);
        endfunction

        function void one_qubit(logic [3:0] kind, int q);
            bit bx;
            bit bz;
            for (int i = 0; i < 2 * nq; i++) begin
                bx = xr[i][q];
                bz = zr[i][q];
                case (kind)
                    stab_pkg::ACT_H: begin
                        sg[i] ^= bx & bz;
                        xr[i][q] = bz;
                        zr[i][q] = bx;
                    end
                    stab_pkg::ACT_S: begin
                        sg[i] ^= bx & bz;
                        zr[i][q] = bz ^ bx;
                    end
                    stab_pkg::ACT_X: sg[i] ^= bz;
                    stab_pkg::ACT_Y: sg[i] ^= bx ^ bz;
                    default: sg[i] ^= bx;
                endcase
            end
        endfunction

        function void cnot(int c, int t);
            bit xc, zc, xt, zt;
            for (int i = 0; i < 2 * nq; i++) begin
                xc = xr[i][c];
                zc = zr[i][c];
                xt = xr[i][t];
                zt = zr[i][t];
                sg[i] ^= xc & zt & (xt ^ zc ^ 1'b1);
                if (xc) xr[i][t] = ~xt;
                if (zt) zr[i][c] = ~zc;
            end
        endfunction

        function bit measure_z(int q, bit rnd);
            int       p;
            int       s;
            bit [1:0] ph;
            p = -1;
            for (int i = nq; i < 2 * nq; i++) begin
                if (p < 0 && xr[i][q]) p = i;
            end
            if (p >= 0) begin
                for (int i = 0; i < 2 * nq; i++) begin
                    if (i != p && xr[i][q]) add_row(p, i);
                end
                xr[p - nq] = xr[p];
                zr[p - nq] = zr[p];
                sg[p - nq] = sg[p];
                xr[p] = '0;
                zr[p] = '0;
                zr[p][q] = 1;
                sg[p] = rnd;
                return rnd;
            end
            scr_x = '0;
            scr_z = '0;
            ph = 0;
            for (int i = 0; i < nq; i++) begin
                if (xr[i][q]) begin
                    s = nq + i;
                    ph = ph + 2 * sg[s] + phase_of(xr[s], zr[s], scr_x, scr_z);
                    scr_x ^= xr[s];
                    scr_z ^= zr[s];
                end
            end
            return ph == 2;
        endfunction

        function void note_input(logic [3:0] act, int a, int b, bit rnd);
            case (act)
                stab_pkg::ACT_RESET: clear_tableau();
                stab_pkg::ACT_H, stab_pkg::ACT_S, stab_pkg::ACT_X, stab_pkg::ACT_Y,
                stab_pkg::ACT_Z: if (a < nq) one_qubit(act, a);
                stab_pkg::ACT_SDG: if (a < nq) repeat (3) one_qubit(stab_pkg::ACT_S, a);
                stab_pkg::ACT_CNOT: if (a < nq && b < nq && a != b) cnot(a, b);
                stab_pkg::ACT_SWAP: if (a < nq && b < nq && a != b) begin
                    cnot(a, b);
                    cnot(b, a);
                    cnot(a, b);
                end
                stab_pkg::ACT_MEAS: outcome_q.push_back((a < nq) ? measure_z(a, rnd) : 1'b0);
                default: ;
            endcase
        endfunction

        function void check_outcome(bit got);
            bit want;
            if (outcome_q.size() == 0) begin
                report($sformatf("unexpected outcome %0d", got));
                return;
            end
            want = outcome_q.pop_front();
            if (got != want) report($sformatf("outcome %0d, expected %0d", got, want));
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_s_axis_tvalid = 0;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 0;
    logic [7:0]  o_m_axis_tdata;
    logic        i_cfg_wen = 0;
    logic [6:0]  i_cfg_wdata = '0;

    tableau_scoreboard sb = new();
    bit  idle_on = 1;
    int  cycles = 0;

    stabilizer_tableau_engine dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 3000000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_m_axis_tready = idle_on ? ($urandom_range(0, 99) >= 19) : 1'b1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) sb.check_outcome(o_m_axis_tdata[0]);
    end

    task automatic send_op(logic [3:0] act, int a, int b, bit rnd);
        @(negedge i_clk);
        while (idle_on && $urandom_range(0, 99) < 19) begin
            i_s_axis_tvalid = 0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1;
        i_s_axis_tdata = {7'b0, rnd, 6'(b), 6'(a), act};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_input(act, a, b, rnd);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_s_axis_tvalid = 0;
        while (sb.outcome_q.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic write_qubits(bit [6:0] v);
        drain();
        @(negedge i_clk);
        i_cfg_wen = 1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_wen = 0;
        sb.configure(v);
    endtask

    task automatic random_ops(int count);
        int r;
        int a;
        int b;
        logic [3:0] act;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 28) act = stab_pkg::ACT_MEAS;
            else if (r < 30) act = stab_pkg::ACT_RESET;
            else if (r < 32) act = 4'($urandom_range(10, 15));
            else if (r < 50) act = ($urandom_range(0, 1)) ? stab_pkg::ACT_CNOT
                                                          : stab_pkg::ACT_SWAP;
            else act = 4'($urandom_range(stab_pkg::ACT_H, stab_pkg::ACT_Z));
            a = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, sb.nq - 1);
            b = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, sb.nq - 1);
            send_op(act, a, b, 1'($urandom()));
        end
    endtask

    initial begin
        bit [6:0] widths[8] = '{7'd1, 7'd64, 7'd7, 7'd33, 7'd2, 7'd0, 7'd127, 7'd40};
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed
        send_op(stab_pkg::ACT_MEAS, 0, 0, 1);
        send_op(stab_pkg::ACT_X, 0, 0, 0);
        send_op(stab_pkg::ACT_MEAS, 0, 0, 0);
        send_op(stab_pkg::ACT_H, 1, 0, 1);
        send_op(stab_pkg::ACT_MEAS, 1, 0, 1);
        send_op(stab_pkg::ACT_MEAS, 1, 0, 0);
        send_op(stab_pkg::ACT_H, 63, 0, 0);
        send_op(stab_pkg::ACT_S, 63, 0, 0);
        send_op(stab_pkg::ACT_SDG, 63, 0, 0);
        send_op(stab_pkg::ACT_Y, 63, 0, 0);
        send_op(stab_pkg::ACT_Z, 63, 0, 0);
        send_op(stab_pkg::ACT_CNOT, 63, 2, 0);
        send_op(stab_pkg::ACT_CNOT, 5, 5, 0);
        send_op(stab_pkg::ACT_SWAP, 63, 0, 0);
        send_op(stab_pkg::ACT_SWAP, 4, 4, 0);
        send_op(4'd10, 0, 0, 0);
        send_op(4'd15, 63, 63, 1);
        send_op(stab_pkg::ACT_MEAS, 63, 0, 0);
        send_op(stab_pkg::ACT_MEAS, 2, 0, 1);
        send_op(stab_pkg::ACT_MEAS, 0, 0, 1);
        send_op(stab_pkg::ACT_RESET, 0, 0, 0);
        send_op(stab_pkg::ACT_MEAS, 0, 0, 1);
        random_ops(100);
        drain();
        random_ops(100);

        foreach (widths[p]) begin
            write_qubits(widths[p]);
            if (p == 3) idle_on = 0;
            random_ops(190);
            idle_on = 1;
        end

        drain();
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

### stabilizer_tableau_engine.f
rtl/stab_pkg.sv
rtl/stab_tab_mem.sv
rtl/stab_row_alu.sv
rtl/stabilizer_tableau_engine.sv
tb/stabilizer_tableau_engine_tb.sv
